### design/load_cell_scale_moving_average_core_macros.svh
// Assertion macros shared by the load-cell scale core modules
`ifndef LOAD_CELL_SCALE_MOVING_AVERAGE_CORE_MACROS_SVH
`define LOAD_CELL_SCALE_MOVING_AVERAGE_CORE_MACROS_SVH

// Same-cycle implication, checked on aclk, off while aresetn is low
`define LCSMA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk, off while aresetn is low
`define LCSMA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/lcsma_pkg.sv
// Shared types and constants for the load-cell scale moving-average core
package lcsma_pkg;

    // Field widths
    localparam int RAW_W      = 24;
    localparam int DIFF_W     = RAW_W + 1;
    localparam int SCALE_W    = 32;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = DIFF_W + SCALE_W;
    localparam int SHR_W      = PROD_W - FRAC_W;
    localparam int GRAMS_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = CFG_IDX_W'(1);

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_GRAMS,
        ST_UPDATE,
        ST_DSTART,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic mul;
        logic grams;
        logic update;
        logic div_init;
        logic div_step;
        logic load_out;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic sample_ok;
        logic div_last;
    } status_t;

endpackage

### design/lcsma_ram.sv
// Generic single-write, single-read RAM with registered read data
module lcsma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/lcsma_ctrl.sv
// Sequencing controller for the load-cell scale core
`include "load_cell_scale_moving_average_core_macros.svh"

module lcsma_ctrl
    import lcsma_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    output cmd_t    cmd,
    input  status_t status
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // State and output-valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL: begin
                // failed read skips straight to the result
                cmd.mul    = 1'b1;
                state_next = status.sample_ok ? ST_GRAMS : ST_EMIT;
            end
            ST_GRAMS: begin
                cmd.grams  = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_DSTART;
            end
            ST_DSTART: begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // wait for the output register to be free
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end
    end

    assign m_valid = m_valid_reg;

    `LCSMA_ASSERT_IMP(a_load_free, cmd.load_out, !m_valid_reg || m_ready, "result word overwritten")
    `LCSMA_ASSERT_NXT(a_accept_busy, s_valid && s_ready, state_reg != ST_IDLE, "accept did not start work")
    `LCSMA_ASSERT_NXT(a_emit_valid, cmd.load_out, m_valid_reg, "loaded result not presented")

endmodule

### design/lcsma_dpath.sv
// Datapath: calibration, gram conversion, history ring, running sum, divider
`include "load_cell_scale_moving_average_core_macros.svh"

module lcsma_dpath
    import lcsma_pkg::*;
#(
    parameter int WINDOW_SIZE = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_wdata,
    input  logic signed [RAW_W-1:0]      s_raw_sample,
    input  logic                         s_read_ok,
    output logic signed [GRAMS_W-1:0]    m_weight_grams,
    output logic                         m_sample_ok,
    input  cmd_t                         cmd,
    output status_t                      status
);

    localparam int ADDR_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);
    localparam int SUM_W  = GRAMS_W + CNT_W;
    localparam int DCNT_W = $clog2(SUM_W);

    // Calibration registers
    logic signed [RAW_W-1:0]   tare_reg;
    logic signed [SCALE_W-1:0] scale_reg;
    logic                      clear_hist;

    // Item capture
    logic signed [RAW_W-1:0] raw_reg;
    logic                    ok_reg;

    // Conversion pipeline
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod_next, prod_reg;
    logic signed [PROD_W-1:0] prod_adj;
    logic signed [SHR_W-1:0]  shr;
    logic [SHR_W-GRAMS_W:0]   shr_hi;
    logic [GRAMS_W-1:0]       grams_next, grams_reg;

    // History state
    logic [CNT_W-1:0]         filled_reg;
    logic [ADDR_W-1:0]        wslot_reg;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic                     full;
    logic [GRAMS_W-1:0]       old_word;

    // Divider
    logic [SUM_W-1:0]  dvd_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic              neg_reg;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    trial_sub;
    logic              qbit;
    logic [SUM_W-1:0]  sum_mag;
    logic [SUM_W-1:0]  quot_signed;

    // Output word
    logic [GRAMS_W-1:0] weight_reg;
    logic               out_ok_reg;

    // Configuration decode; any known register write clears the history
    always_comb begin
        clear_hist = 1'b0;
        unique case (cfg_index)
            CFG_TARE:  clear_hist = cfg_we;
            CFG_SCALE: clear_hist = cfg_we;
            default:   clear_hist = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tare_reg  <= '0;
            scale_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_index == CFG_TARE) begin
                tare_reg <= cfg_wdata[RAW_W-1:0];
            end
            if (cfg_index == CFG_SCALE) begin
                scale_reg <= cfg_wdata[SCALE_W-1:0];
            end
        end
    end

    // Tare offset times Q16.16 scale
    assign diff      = DIFF_W'(tare_reg) - DIFF_W'(raw_reg);
    assign prod_next = diff * scale_reg;

    // Drop fraction toward zero, then saturate to 32 bits
    assign prod_adj   = prod_reg + (prod_reg[PROD_W-1] ? PROD_W'((1 << FRAC_W) - 1) : '0);
    assign shr        = prod_adj[PROD_W-1:FRAC_W];
    assign shr_hi     = shr[SHR_W-1:GRAMS_W-1];
    always_comb begin
        if ((&shr_hi) || (~|shr_hi)) begin
            grams_next = shr[GRAMS_W-1:0];
        end else if (shr[SHR_W-1]) begin
            grams_next = {1'b1, {(GRAMS_W-1){1'b0}}};
        end else begin
            grams_next = {1'b0, {(GRAMS_W-1){1'b1}}};
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            raw_reg <= s_raw_sample;
            ok_reg  <= s_read_ok;
        end
        if (cmd.mul) begin
            prod_reg <= prod_next;
        end
        if (cmd.grams) begin
            grams_reg <= grams_next;
        end
    end

    // History ring: old word read in the multiply cycle, new word written on update
    lcsma_ram #(
        .WIDTH (GRAMS_W),
        .DEPTH (WINDOW_SIZE),
        .ADDR_W(ADDR_W)
    ) u_ring (
        .aclk (aclk),
        .we   (cmd.update),
        .waddr(wslot_reg),
        .wdata(grams_reg),
        .re   (cmd.mul),
        .raddr(wslot_reg),
        .rdata(old_word)
    );

    // Running sum of the stored words
    assign full     = (filled_reg == CNT_W'(WINDOW_SIZE));
    assign sum_next = sum_reg
                    + {{(SUM_W-GRAMS_W){grams_reg[GRAMS_W-1]}}, grams_reg}
                    - (full ? {{(SUM_W-GRAMS_W){old_word[GRAMS_W-1]}}, old_word} : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filled_reg <= '0;
            wslot_reg  <= '0;
            sum_reg    <= '0;
        end else if (clear_hist) begin
            filled_reg <= '0;
            wslot_reg  <= '0;
            sum_reg    <= '0;
        end else if (cmd.update) begin
            sum_reg <= sum_next;
            if (!full) begin
                filled_reg <= filled_reg + CNT_W'(1);
            end
            if (wslot_reg == ADDR_W'(WINDOW_SIZE - 1)) begin
                wslot_reg <= '0;
            end else begin
                wslot_reg <= wslot_reg + ADDR_W'(1);
            end
        end
    end

    // Restoring divider on magnitudes, one quotient bit a cycle
    assign sum_mag   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign trial     = {rem_reg, dvd_reg[SUM_W-1]};
    assign qbit      = (trial >= {1'b0, filled_reg});
    assign trial_sub = trial - {1'b0, filled_reg};

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            dvd_reg  <= sum_mag;
            rem_reg  <= '0;
            dcnt_reg <= '0;
            neg_reg  <= sum_reg[SUM_W-1];
        end else if (cmd.div_step) begin
            dvd_reg  <= {dvd_reg[SUM_W-2:0], qbit};
            rem_reg  <= qbit ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
            dcnt_reg <= dcnt_reg + DCNT_W'(1);
        end
    end

    assign status.div_last  = (dcnt_reg == DCNT_W'(SUM_W - 1));
    assign status.sample_ok = ok_reg;

    // Result word: restore the sign of the mean, zero after a failed read
    assign quot_signed = neg_reg ? (~dvd_reg + SUM_W'(1)) : dvd_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            weight_reg <= ok_reg ? quot_signed[GRAMS_W-1:0] : '0;
            out_ok_reg <= ok_reg;
        end
    end

    assign m_weight_grams = weight_reg;
    assign m_sample_ok    = out_ok_reg;

    `LCSMA_ASSERT_IMP(a_fill_bound, 1'b1, filled_reg <= CNT_W'(WINDOW_SIZE), "fill count past window")
    `LCSMA_ASSERT_IMP(a_slot_bound, 1'b1, wslot_reg <= ADDR_W'(WINDOW_SIZE - 1), "write slot past window")
    `LCSMA_ASSERT_NXT(a_fill_grows, cmd.update && !clear_hist, filled_reg != '0, "divisor zero after update")

endmodule

### design/load_cell_scale_moving_average_core.sv
// Top level of the load-cell scale core with tare, Q16.16 scale and moving average
//
//  word    | direction | ports
//  --------+-----------+-----------------------------------------------------
//  cfg     | in        | cfg_valid, cfg_ready, cfg_index, cfg_wdata
//  input   | in        | s_valid, s_ready, s_raw_sample, s_read_ok
//  result  | out       | m_valid, m_ready, m_weight_grams, m_sample_ok
//
// One word at a time. A good read goes through the bit-serial mean divider over the
// SUM_W-bit sum (SUM_W = 32 + clog2(WINDOW_SIZE+1), 37 at a window of 16); a failed
// read skips it. Reset is synchronous on aresetn; no clearing pass, the fill count
// masks unwritten ring entries. A new word is accepted while a result waits on
// m_ready; a stalled result only holds the controller at its last step.
module load_cell_scale_moving_average_core
    import lcsma_pkg::*;
#(
    parameter int WINDOW_SIZE = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_wdata,
    // input channel
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [RAW_W-1:0]   s_raw_sample,
    input  logic                      s_read_ok,
    // result channel
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [GRAMS_W-1:0] m_weight_grams,
    output logic                      m_sample_ok
);

    cmd_t    cmd;
    status_t status;

    // Configuration is always taken
    assign cfg_ready = 1'b1;

    lcsma_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .cmd    (cmd),
        .status (status)
    );

    lcsma_dpath #(
        .WINDOW_SIZE(WINDOW_SIZE)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_raw_sample  (s_raw_sample),
        .s_read_ok     (s_read_ok),
        .m_weight_grams(m_weight_grams),
        .m_sample_ok   (m_sample_ok),
        .cmd           (cmd),
        .status        (status)
    );

endmodule
